[design/phcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phcs_pkg
// Shared types and constants for the phase current sense calibration block.
// ----------------------------------------------------------------------------
package phcs_pkg;

	localparam int CUR_W   = 29;
	localparam int CURC_W  = 30;
	localparam int OFS_W   = 12;
	localparam int SCALE_W = 16;
	localparam int CFG_W   = 16;
	localparam int CNT_W   = 16;
	localparam int MX_W    = 30;
	localparam int MY_W    = 17;
	localparam int PROD_W  = MX_W + MY_W;

	localparam logic signed [PROD_W-1:0] CUR_LIM = PROD_W'(268435455);

	typedef logic [1:0] req_t;
	localparam req_t REQ_SAMPLE    = 2'd0;
	localparam req_t REQ_CAL_BEGIN = 2'd1;
	localparam req_t REQ_CAL_END   = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SCALE  = 2'd0;
	localparam cfg_idx_t CFG_OFS_A  = 2'd1;
	localparam cfg_idx_t CFG_OFS_B  = 2'd2;
	localparam cfg_idx_t CFG_ALPHA  = 2'd3;

	typedef logic signed [CUR_W-1:0]  cur_t;
	typedef logic signed [CURC_W-1:0] curc_t;
	typedef logic [OFS_W-1:0]         ofs_t;

endpackage

[design/phase_current_sense_calibrate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_current_sense_calibrate
// Two-phase current sense with offset subtraction, scaling, first-order
// exponential filter and ADC offset calibration by averaging.
// ----------------------------------------------------------------------------
// channel   signals                               direction
// in        in_valid in_stall req_type adc_a adc_b   receive
// out       out_valid out_stall cur_* filt_* ...      send
// cfg       cfg_we cfg_idx cfg_data                   receive, write only
//
// A sample runs four products on the one shared multiplier and the last
// filter update, then loads its result in ST_DONE once the output is free;
// the next transaction is taken back in ST_IDLE. An end command with a
// nonzero count runs the one-bit-per-cycle restoring divider twice, once
// per phase, and loads its result the same way; other commands go straight
// to ST_DONE. Reset clears control and calibration state and sets config
// defaults; product, ADC input and result data registers are not reset.
// A new transaction is taken while the previous result waits under stall.
// ----------------------------------------------------------------------------
module phase_current_sense_calibrate #(
	parameter int ADC_BITS        = 12,
	parameter int MAX_CAL_SAMPLES = 65535
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  phcs_pkg::cfg_idx_t         cfg_idx,
	input  logic [phcs_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  phcs_pkg::req_t             req_type,
	input  logic [ADC_BITS-1:0]        adc_a,
	input  logic [ADC_BITS-1:0]        adc_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output phcs_pkg::cur_t             cur_a,
	output phcs_pkg::cur_t             cur_b,
	output phcs_pkg::curc_t            cur_c,
	output phcs_pkg::cur_t             filt_a,
	output phcs_pkg::cur_t             filt_b,
	output phcs_pkg::curc_t            filt_c,
	output logic                       calibrating,
	output phcs_pkg::ofs_t             eff_offset_a,
	output phcs_pkg::ofs_t             eff_offset_b,
	output logic [phcs_pkg::CNT_W-1:0] cal_count
);
	import phcs_pkg::*;

	localparam int CW  = $clog2(MAX_CAL_SAMPLES + 1);
	localparam int SW  = ADC_BITS + CW;
	localparam int BCW = $clog2(SW);
	localparam int DW  = ((ADC_BITS > OFS_W) ? ADC_BITS : OFS_W) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]               state_q;
	logic [2:0]               step_q;
	logic                     div_sel_q;
	logic [BCW-1:0]           bit_q;

	logic [SCALE_W-1:0]       scale_q;
	ofs_t                     ofs_a_init_q;
	ofs_t                     ofs_b_init_q;
	logic [SCALE_W-1:0]       alpha_q;

	logic [ADC_BITS-1:0]      adc_a_q;
	logic [ADC_BITS-1:0]      adc_b_q;

	cur_t                     last_a_q;
	cur_t                     last_b_q;
	cur_t                     filt_a_q;
	cur_t                     filt_b_q;
	logic                     cal_active_q;
	logic                     have_cal_q;
	logic [SW-1:0]            sum_a_q;
	logic [SW-1:0]            sum_b_q;
	logic [CW-1:0]            count_q;
	ofs_t                     cal_ofs_a_q;
	ofs_t                     cal_ofs_b_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [MX_W-1:0]   mul_x;
	logic signed [MY_W-1:0]   mul_y;

	logic [SW-1:0]            dq_q;
	logic [CW:0]              rem_q;
	logic [CW:0]              trial;
	logic                     trial_ge;

	ofs_t                     off_a;
	ofs_t                     off_b;
	logic signed [DW-1:0]     diff_a;
	logic signed [DW-1:0]     diff_b;
	logic signed [MX_W-1:0]   err_a;
	logic signed [MX_W-1:0]   err_b;
	logic signed [CURC_W:0]   filt_upd;
	cur_t                     sat_prod;
	logic                     in_acc;
	logic                     out_free;

	assign off_a  = have_cal_q ? cal_ofs_a_q : ofs_a_init_q;
	assign off_b  = have_cal_q ? cal_ofs_b_q : ofs_b_init_q;
	assign diff_a = $signed(DW'(adc_a_q)) - $signed(DW'(off_a));
	assign diff_b = $signed(DW'(adc_b_q)) - $signed(DW'(off_b));
	assign err_a  = MX_W'(last_a_q) - MX_W'(filt_a_q);
	assign err_b  = MX_W'(last_b_q) - MX_W'(filt_b_q);

	always_comb begin
		mul_x = MX_W'(diff_a);
		mul_y = $signed({1'b0, scale_q});
		case (step_q)
			3'd0: begin
				mul_x = MX_W'(diff_a);
				mul_y = $signed({1'b0, scale_q});
			end
			3'd1: begin
				mul_x = MX_W'(diff_b);
				mul_y = $signed({1'b0, scale_q});
			end
			3'd2: begin
				mul_x = err_a;
				mul_y = $signed({1'b0, alpha_q});
			end
			3'd3: begin
				mul_x = err_b;
				mul_y = $signed({1'b0, alpha_q});
			end
			default: begin
				mul_x = MX_W'(diff_a);
				mul_y = $signed({1'b0, scale_q});
			end
		endcase
	end

	always_comb begin
		if (prod_q > CUR_LIM)
			sat_prod = CUR_W'(CUR_LIM);
		else if (prod_q < -CUR_LIM)
			sat_prod = CUR_W'(-CUR_LIM);
		else
			sat_prod = CUR_W'(prod_q);
	end

	always_comb begin
		if (step_q == 3'd3)
			filt_upd = (CURC_W+1)'(filt_a_q) + (CURC_W+1)'(prod_q >>> 16);
		else
			filt_upd = (CURC_W+1)'(filt_b_q) + (CURC_W+1)'(prod_q >>> 16);
	end

	assign trial    = {rem_q[CW-1:0], dq_q[SW-1]};
	assign trial_ge = trial >= {1'b0, count_q};

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= SCALE_W'(1024);
			ofs_a_init_q <= OFS_W'(2048);
			ofs_b_init_q <= OFS_W'(2048);
			alpha_q      <= SCALE_W'(6554);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SCALE: scale_q      <= cfg_data;
				CFG_OFS_A: ofs_a_init_q <= cfg_data[OFS_W-1:0];
				CFG_OFS_B: ofs_b_init_q <= cfg_data[OFS_W-1:0];
				CFG_ALPHA: alpha_q      <= cfg_data;
				default:   scale_q      <= scale_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_x * mul_y);
		if (in_acc) begin
			adc_a_q <= adc_a;
			adc_b_q <= adc_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			div_sel_q    <= 1'b0;
			bit_q        <= '0;
			last_a_q     <= '0;
			last_b_q     <= '0;
			filt_a_q     <= '0;
			filt_b_q     <= '0;
			cal_active_q <= 1'b0;
			have_cal_q   <= 1'b0;
			sum_a_q      <= '0;
			sum_b_q      <= '0;
			count_q      <= '0;
			cal_ofs_a_q  <= '0;
			cal_ofs_b_q  <= '0;
			dq_q         <= '0;
			rem_q        <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						case (req_type)
							REQ_SAMPLE: begin
								state_q <= ST_MUL;
								if (cal_active_q && count_q < CW'(MAX_CAL_SAMPLES)) begin
									sum_a_q <= sum_a_q + SW'(adc_a);
									sum_b_q <= sum_b_q + SW'(adc_b);
									count_q <= count_q + 1'b1;
								end
							end
							REQ_CAL_BEGIN: begin
								cal_active_q <= 1'b1;
								sum_a_q      <= '0;
								sum_b_q      <= '0;
								count_q      <= '0;
								state_q      <= ST_DONE;
							end
							REQ_CAL_END: begin
								cal_active_q <= 1'b0;
								if (count_q != '0) begin
									state_q   <= ST_DIV;
									div_sel_q <= 1'b0;
									bit_q     <= BCW'(SW - 1);
									dq_q      <= sum_a_q;
									rem_q     <= '0;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						3'd1: last_a_q <= sat_prod;
						3'd2: last_b_q <= sat_prod;
						3'd3: filt_a_q <= CUR_W'(filt_upd);
						3'd4: begin
							filt_b_q <= CUR_W'(filt_upd);
							state_q  <= ST_DONE;
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					if (bit_q != '0) begin
						dq_q  <= {dq_q[SW-2:0], trial_ge};
						rem_q <= trial_ge ? (trial - {1'b0, count_q}) : trial;
						bit_q <= bit_q - 1'b1;
					end else if (!div_sel_q) begin
						cal_ofs_a_q <= OFS_W'({dq_q[SW-2:0], trial_ge});
						div_sel_q   <= 1'b1;
						bit_q       <= BCW'(SW - 1);
						dq_q        <= sum_b_q;
						rem_q       <= '0;
					end else begin
						cal_ofs_b_q <= OFS_W'({dq_q[SW-2:0], trial_ge});
						have_cal_q  <= 1'b1;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			cur_a        <= last_a_q;
			cur_b        <= last_b_q;
			cur_c        <= -CURC_W'(last_a_q) - CURC_W'(last_b_q);
			filt_a       <= filt_a_q;
			filt_b       <= filt_b_q;
			filt_c       <= -CURC_W'(filt_a_q) - CURC_W'(filt_b_q);
			calibrating  <= cal_active_q;
			eff_offset_a <= off_a;
			eff_offset_b <= off_b;
			cal_count    <= CNT_W'(count_q);
		end
	end

endmodule
